// File: rtl/core/spi_rcf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_rcf_pkg
// Types and constants shared by the SPI register command framer.
// ---------------------------------------------------------------------------
package spi_rcf_pkg;

  // transaction modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_PAGE  = 2'd2;
  localparam logic [1:0] MODE_INSTR = 2'd3;

  // command byte prefixes
  localparam logic [7:0] PFX_WRITE = 8'h40;
  localparam logic [7:0] PFX_READ  = 8'h00;
  localparam logic [7:0] PFX_PAGE  = 8'h80;
  localparam logic [7:0] PFX_INSTR = 8'hC0;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // byte index within a transaction (up to six bytes)
  localparam int IDX_W = 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  target;
    logic [23:0] write_data;
    logic        checksum_on;
    logic [23:0] rx_data;
    logic [7:0]  rx_checksum;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [23:0] read_value;
    logic        status;
  } out_item_t;

  // 0xFF minus the byte sum of a 24-bit word, modulo 256
  function automatic logic [7:0] chk3(input logic [23:0] w);
    logic [7:0] s;
    s = w[23:16] + w[15:8] + w[7:0];
    return ~s;
  endfunction

endpackage

// File: rtl/core/spi_rcf_byte_sel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_rcf_byte_sel
// Picks the transmit byte, last marker and read result for one byte index.
// ---------------------------------------------------------------------------
module spi_rcf_byte_sel (
  input  spi_rcf_pkg::in_item_t  item,
  input  spi_rcf_pkg::idx_t      idx,
  output spi_rcf_pkg::out_item_t res
);
  import spi_rcf_pkg::*;

  logic [7:0] tgt_b;
  logic [7:0] tgt_chk;
  logic [7:0] byte_v;
  logic       last_v;
  logic       rd_mismatch;

  assign tgt_b       = {2'b00, item.target};
  assign tgt_chk     = ~tgt_b;
  assign rd_mismatch = (item.rx_checksum != chk3(item.rx_data));

  always_comb begin
    byte_v = FILL_BYTE;
    last_v = 1'b0;
    unique case (item.mode)
      MODE_WRITE: begin
        unique case (idx)
          3'd0:    byte_v = PFX_WRITE | tgt_b;
          3'd1:    byte_v = item.write_data[23:16];
          3'd2:    byte_v = item.write_data[15:8];
          3'd3: begin
            byte_v = item.write_data[7:0];
            last_v = ~item.checksum_on;
          end
          default: begin
            byte_v = chk3(item.write_data);
            last_v = 1'b1;
          end
        endcase
      end
      MODE_READ: begin
        if (idx == '0) begin
          byte_v = PFX_READ | tgt_b;
        end else if (item.checksum_on && idx == 3'd1) begin
          byte_v = tgt_chk;
        end
        last_v = item.checksum_on ? (idx == 3'd5) : (idx == 3'd3);
      end
      MODE_PAGE, MODE_INSTR: begin
        if (idx == '0) begin
          byte_v = ((item.mode == MODE_PAGE) ? PFX_PAGE : PFX_INSTR) | tgt_b;
          last_v = ~item.checksum_on;
        end else begin
          byte_v = tgt_chk;
          last_v = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.tx_byte    = byte_v;
    res.last_byte  = last_v;
    res.read_value = '0;
    res.status     = 1'b0;
    if (item.mode == MODE_READ && last_v) begin
      res.read_value = item.rx_data;
      res.status     = item.checksum_on & rd_mismatch;
    end
  end

endmodule

// File: rtl/core/spi_register_command_framer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_register_command_framer_core
// Host-side byte framer for register access to an SPI metering device.
// ---------------------------------------------------------------------------
// A request (one transaction) is taken when start is high and busy is low.
// It is turned into its transmit bytes in bus order, one byte per clock on
// out_item with out_valid high for that single cycle; the receiver cannot
// stall, so each byte must be consumed in the cycle it is shown. A write
// gives 4 bytes (5 with checksum), a read 4 (6), page select and
// instruction 1 (2). busy drops during the cycle the final byte is being
// formed, so the next request enters while the previous final byte goes to
// the output register and bytes stream without gaps. The first byte is
// formed from item_r, loaded at the accepting edge, and then passes
// through the output register. On the final byte of a read, read_value
// carries the captured rx_data and status flags a checksum mismatch
// (checksum on only); both are zero on every other byte.
// ---------------------------------------------------------------------------
module spi_register_command_framer_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  spi_rcf_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output spi_rcf_pkg::out_item_t out_item
);
  import spi_rcf_pkg::*;

  // request held for the length of its byte sequence
  in_item_t  item_r;
  idx_t      idx_r;
  idx_t      idx_nxt;
  logic      act_r;
  logic      act_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  out_item_t sel;
  logic      accept;

  spi_rcf_byte_sel u_sel (
    .item (item_r),
    .idx  (idx_r),
    .res  (sel)
  );

  // free once the byte being formed is the final one
  assign busy   = act_r & ~sel.last_byte;
  assign accept = start & ~busy;

  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    if (accept) begin
      act_nxt = 1'b1;
      idx_nxt = '0;
    end else if (act_r) begin
      // reached on every byte but the final one, and on the final byte when no new request came
      act_nxt = ~sel.last_byte;
      idx_nxt = idx_r + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= act_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    out_item_r <= sel;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for spi_register_command_framer_core. Requests are
// queued up front, driven on the falling edge with random hold-offs, and
// every transmit byte seen on out_item is checked field by field against
// the byte stream predicted for each accepted request.
// ---------------------------------------------------------------------------
module testbench;
  import spi_rcf_pkg::*;

  localparam int CYCLE_LIMIT = 40000;

  // a queued request and the chance, in percent, that the sender holds off
  typedef struct {
    in_item_t    req;
    int unsigned gap_pct;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start_r = 1'b0;
  in_item_t  item_r = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  pending_t  pend_q[$];      // requests not yet offered
  out_item_t tx_expect_q[$]; // predicted bytes, oldest first
  bit        drive_en = 1'b0;
  bit        req_taken = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_bytes = 0;
  int unsigned n_chk_reads = 0;
  int unsigned n_bad_chk = 0;

  spi_register_command_framer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .busy     (busy),
    .in_item  (item_r),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // 0xFF less the byte sum of a 24-bit word, wrapping at 256
  function automatic logic [7:0] sum_complement(input logic [23:0] w);
    logic [7:0] total;
    total = w[23:16] + w[15:8] + w[7:0];
    return 8'hFF - total;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic [23:0] value, input logic stat);
    out_item_t o;
    o.tx_byte    = b;
    o.last_byte  = last;
    o.read_value = value;
    o.status     = stat;
    tx_expect_q.push_back(o);
  endtask

  // Byte stream that one request should produce on the bus.
  task automatic frame_request(input in_item_t r);
    logic [7:0] tgt;
    logic       stat;
    tgt = {2'b00, r.target};
    case (r.mode)
      MODE_WRITE: begin
        push_byte(PFX_WRITE | tgt, 1'b0, '0, 1'b0);
        push_byte(r.write_data[23:16], 1'b0, '0, 1'b0);
        push_byte(r.write_data[15:8], 1'b0, '0, 1'b0);
        push_byte(r.write_data[7:0], !r.checksum_on, '0, 1'b0);
        if (r.checksum_on)
          push_byte(sum_complement(r.write_data), 1'b1, '0, 1'b0);
      end
      MODE_READ: begin
        // rx_checksum only matters when the checksum is enabled
        stat = r.checksum_on && (r.rx_checksum != sum_complement(r.rx_data));
        push_byte(PFX_READ | tgt, 1'b0, '0, 1'b0);
        if (r.checksum_on) begin
          push_byte(8'hFF - tgt, 1'b0, '0, 1'b0);
          n_chk_reads++;
          if (stat) n_bad_chk++;
        end
        push_byte(FILL_BYTE, 1'b0, '0, 1'b0);
        push_byte(FILL_BYTE, 1'b0, '0, 1'b0);
        if (r.checksum_on)
          push_byte(FILL_BYTE, 1'b0, '0, 1'b0);
        push_byte(FILL_BYTE, 1'b1, r.rx_data, stat);
      end
      default: begin
        // page select and instruction share one shape
        push_byte(((r.mode == MODE_PAGE) ? PFX_PAGE : PFX_INSTR) | tgt,
                  !r.checksum_on, '0, 1'b0);
        if (r.checksum_on)
          push_byte(8'hFF - tgt, 1'b1, '0, 1'b0);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_request(input logic [1:0] mode, input logic [5:0] tgt,
                               input logic [23:0] wd, input logic cs,
                               input logic [23:0] rx, input logic [7:0] rxc,
                               input int unsigned gap);
    pending_t p;
    p.req.mode        = mode;
    p.req.target      = tgt;
    p.req.write_data  = wd;
    p.req.checksum_on = cs;
    p.req.rx_data     = rx;
    p.req.rx_checksum = rxc;
    p.gap_pct         = gap;
    pend_q.push_back(p);
  endtask

  // Random request; reads with checksum get a matching checksum about half
  // the time so both outcomes of the check turn up often.
  task automatic queue_random(input int unsigned gap);
    logic [23:0] rx;
    logic [7:0]  rxc;
    logic [1:0]  mode;
    logic        cs;
    mode = 2'($urandom_range(0, 3));
    cs   = 1'($urandom_range(0, 1));
    rx   = 24'($urandom_range(0, 32'hFF_FFFF));
    rxc  = 8'($urandom_range(0, 255));
    if (mode == MODE_READ && cs && $urandom_range(0, 1))
      rxc = sum_complement(rx);
    queue_request(mode, 6'($urandom_range(0, 63)),
                  24'($urandom_range(0, 32'hFF_FFFF)), cs, rx, rxc, gap);
  endtask

  // Driver: present the head of the queue on the falling edge. A request
  // stays up until the rising edge takes it; only then is the next one
  // considered, possibly after a random hold-off.
  always @(negedge clk) begin : drive
    logic     go;
    in_item_t nxt;
    go  = start_r;
    nxt = item_r;
    if (drive_en && (!start_r || req_taken)) begin
      go = 1'b0;
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= pend_q[0].gap_pct) begin
        nxt = pend_q[0].req;
        pend_q.pop_front();
        go = 1'b1;
      end
    end
    start_r <= go;
    item_r  <= nxt;
  end

  // Monitor: check the byte on the bus first, then note any request taken
  // at this edge. The first byte of a request only reaches the bus through the
  // framer's registers, so the order of the two never matters.
  always @(posedge clk) begin : watch
    out_item_t want;
    req_taken <= rst_n && start_r && !busy;
    if (rst_n && out_valid) begin
      n_bytes++;
      if (tx_expect_q.size() == 0) begin
        $error("unexpected byte 0x%0h on the bus", out_item.tx_byte);
        errors++;
      end else begin
        want = tx_expect_q.pop_front();
        check_field("tx_byte", 24'(want.tx_byte), 24'(out_item.tx_byte));
        check_field("last_byte", 24'(want.last_byte), 24'(out_item.last_byte));
        check_field("read_value", want.read_value, out_item.read_value);
        check_field("status", 24'(want.status), 24'(out_item.status));
      end
    end
    if (rst_n && start_r && !busy) begin
      frame_request(item_r);
      n_accepted++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // Directed requests: field extremes, every mode with and without the
    // checksum, good and bad read checksums, and junk in unused fields.
    queue_request(MODE_WRITE, 6'd0, 24'h000000, 1'b0, 24'h000000, 8'h00, 35);
    queue_request(MODE_WRITE, 6'd63, 24'hFFFFFF, 1'b1, 24'h000000, 8'h00, 35);
    queue_request(MODE_WRITE, 6'd21, 24'h123456, 1'b1, 24'h000000, 8'h00, 35);
    queue_request(MODE_WRITE, 6'd42, 24'hA5A5A5, 1'b0, 24'h000000, 8'h00, 35);
    queue_request(MODE_WRITE, 6'd5, 24'h5A5A5A, 1'b1, 24'hFFFFFF, 8'hFF, 35);
    queue_request(MODE_READ, 6'd0, 24'h000000, 1'b0, 24'h000000, 8'h5A, 35);
    queue_request(MODE_READ, 6'd63, 24'h000000, 1'b0, 24'hFFFFFF, 8'hFF, 35);
    queue_request(MODE_READ, 6'd10, 24'h000000, 1'b1, 24'h000000,
                  sum_complement(24'h000000), 35);
    queue_request(MODE_READ, 6'd63, 24'h000000, 1'b1, 24'hFFFFFF,
                  sum_complement(24'hFFFFFF), 35);
    queue_request(MODE_READ, 6'd33, 24'h000000, 1'b1, 24'h123456,
                  sum_complement(24'h123456) + 8'd1, 35);
    queue_request(MODE_READ, 6'd0, 24'h000000, 1'b1, 24'hFFFFFF, 8'h00, 35);
    queue_request(MODE_READ, 6'd17, 24'hFFFFFF, 1'b1, 24'hC3A501,
                  sum_complement(24'hC3A501), 35);
    queue_request(MODE_PAGE, 6'd0, 24'h000000, 1'b0, 24'h000000, 8'h00, 35);
    queue_request(MODE_PAGE, 6'd63, 24'h000000, 1'b1, 24'h000000, 8'h00, 35);
    queue_request(MODE_PAGE, 6'd12, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 8'hFF, 35);
    queue_request(MODE_INSTR, 6'd0, 24'h000000, 1'b1, 24'h000000, 8'h00, 35);
    queue_request(MODE_INSTR, 6'd63, 24'h000000, 1'b0, 24'h000000, 8'h00, 35);
    queue_request(MODE_INSTR, 6'd42, 24'h9E3779, 1'b1, 24'h7F7F7F, 8'h80, 35);
    // random traffic: sender hold-off 35 %, then 46 %, then none
    repeat (37) queue_random(35);
    repeat (37) queue_random(46);
    repeat (37) queue_random(0);

    repeat (12) @(negedge clk);
    rst_n    <= 1'b1;
    drive_en <= 1'b1;

    // all requests taken, then every predicted byte seen
    while (pend_q.size() != 0 || start_r) @(posedge clk);
    while (tx_expect_q.size() != 0) @(posedge clk);
    // allow for stray bytes after the last expected one
    repeat (16) @(posedge clk);

    $display("Covered %0d requests, %0d bytes checked", n_accepted, n_bytes);
    $display("Checked reads: %0d, of which %0d with a checksum mismatch",
             n_chk_reads, n_bad_chk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/spi_rcf_pkg.sv
rtl/core/spi_rcf_byte_sel.sv
rtl/core/spi_register_command_framer_core.sv
test/testbench.sv
